// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL. Every check is sampled on the rising
// edge of clock and is switched off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

`define ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/efra_pkg.sv =====
package efra_pkg;

   localparam int TIME_W       = 40;
   localparam int COUNT_W      = 24;
   localparam int REQ_TIME_W   = 32;
   localparam int ROOM_OUT_W   = 4;
   localparam int ACTIVE_W     = 5;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int DEF_MAX_ROOMS = 16;

   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;
   localparam logic [TIME_W-1:0]   TIME_MAX     = {TIME_W{1'b1}};
   localparam logic [COUNT_W-1:0]  COUNT_MAX    = {COUNT_W{1'b1}};

   typedef struct packed {
      logic [REQ_TIME_W-1:0] req_start;
      logic [REQ_TIME_W-1:0] req_end;
   } req_type;

   typedef struct packed {
      logic [ROOM_OUT_W-1:0] assigned_room;
      logic                  was_delayed;
      logic [TIME_W-1:0]     actual_begin;
      logic [TIME_W-1:0]     actual_finish;
      logic [ROOM_OUT_W-1:0] busiest_room;
      logic [COUNT_W-1:0]    busiest_count;
   } rsp_type;

endpackage

// ===== rtl/core/earliest_free_room_allocator.sv =====
// A booking runs through the scan, drain and update states, registering its
// result at the write-back. The scan covers the n active rooms (1 to 16 at the
// default size), one room per cycle through the single read port of the room
// memories; a new booking is taken only when idle. Reset (synchronous, active
// high) makes all room times and counts read as zero and sets active_rooms to
// 16. The receiver cannot stall; each result is a one-cycle strobe.
`include "assert_macros.svh"

module earliest_free_room_allocator
   import efra_pkg::*;
#(
   parameter int MAX_ROOMS = DEF_MAX_ROOMS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   output rsp_type               rsp_payload,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int ROOM_W = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_DRAIN  = 2'd2;
   localparam logic [1:0] S_UPDATE = 2'd3;

   localparam logic REG_ACTIVE_ROOMS = 1'b0;

   // Configuration register
   logic [ACTIVE_W-1:0] active_ff;
   logic                csr_wr;
   logic                csr_sel_active;

   assign pready         = 1'b1;
   assign csr_sel_active = (paddr[2] == REG_ACTIVE_ROOMS);
   assign csr_wr         = psel && penable && pwrite && csr_sel_active;
   assign prdata         = csr_sel_active
                           ? {{(CSR_DATA_W-ACTIVE_W){1'b0}}, active_ff}
                           : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_RESET;
      end else if (csr_wr) begin
         active_ff <= pwdata[ACTIVE_W-1:0];
      end
   end

   // Number of rooms in use, held as the index of the last one.
   logic [ROOM_W-1:0] last_in;
   always_comb begin
      int n;
      n = int'(active_ff);
      if (n < 1) begin
         n = 1;
      end
      if (n > MAX_ROOMS) begin
         n = MAX_ROOMS;
      end
      last_in = ROOM_W'(n - 1);
   end

   // Control
   logic [1:0]        state_ff, state_in;
   logic [ROOM_W-1:0] issue_ff, issue_in;
   logic [ROOM_W-1:0] last_ff;
   logic              accept;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   always_comb begin
      state_in = state_ff;
      issue_in = issue_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_SCAN;
               issue_in = '0;
            end
         end
         S_SCAN: begin
            issue_in = issue_ff + ROOM_W'(1);
            if (issue_ff == last_ff) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         issue_ff <= '0;
      end else begin
         state_ff <= state_in;
         issue_ff <= issue_in;
      end
   end

   // Request registers
   logic [REQ_TIME_W-1:0] start_ff;
   logic [REQ_TIME_W-1:0] dur_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         start_ff <= req_payload.req_start;
         dur_ff   <= (req_payload.req_end > req_payload.req_start)
                     ? (req_payload.req_end - req_payload.req_start) : '0;
         last_ff  <= last_in;
      end
   end

   // Room memories; an entry never written since reset reads as zero.
   logic [TIME_W-1:0]    bu_mem  [MAX_ROOMS];
   logic [COUNT_W-1:0]   cnt_mem [MAX_ROOMS];
   logic [MAX_ROOMS-1:0] written_ff;

   logic [TIME_W-1:0]  bu_q_ff;
   logic [COUNT_W-1:0] cnt_q_ff;
   logic               wr_q_ff;
   logic [ROOM_W-1:0]  idx_q_ff;
   logic               q_vld_ff;
   logic [TIME_W-1:0]  bu_q;
   logic [COUNT_W-1:0] cnt_q;

   logic               mem_we;
   logic [ROOM_W-1:0]  wr_room;
   logic [TIME_W-1:0]  wr_bu;
   logic [COUNT_W-1:0] wr_cnt;

   always_ff @(posedge clock) begin
      if (state_ff == S_SCAN) begin
         bu_q_ff  <= bu_mem[issue_ff];
         cnt_q_ff <= cnt_mem[issue_ff];
         wr_q_ff  <= written_ff[issue_ff];
         idx_q_ff <= issue_ff;
      end
      if (mem_we) begin
         bu_mem[wr_room]  <= wr_bu;
         cnt_mem[wr_room] <= wr_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
         q_vld_ff   <= 1'b0;
      end else begin
         q_vld_ff <= (state_ff == S_SCAN);
         if (mem_we) begin
            written_ff[wr_room] <= 1'b1;
         end
      end
   end

   assign bu_q  = wr_q_ff ? bu_q_ff : '0;
   assign cnt_q = wr_q_ff ? cnt_q_ff : '0;

   // Scan trackers: first free room, earliest-free room, busiest room.
   logic               found_ff;
   logic [ROOM_W-1:0]  free_room_ff;
   logic [COUNT_W-1:0] free_cnt_ff;
   logic [ROOM_W-1:0]  early_room_ff;
   logic [TIME_W-1:0]  early_bu_ff;
   logic [COUNT_W-1:0] early_cnt_ff;
   logic [ROOM_W-1:0]  best_room_ff;
   logic [COUNT_W-1:0] best_cnt_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         found_ff     <= 1'b0;
         best_room_ff <= '0;
         best_cnt_ff  <= '0;
      end else if (q_vld_ff) begin
         if (!found_ff && (bu_q <= {{(TIME_W-REQ_TIME_W){1'b0}}, start_ff})) begin
            found_ff     <= 1'b1;
            free_room_ff <= idx_q_ff;
            free_cnt_ff  <= cnt_q;
         end
         if ((idx_q_ff == '0) || (bu_q < early_bu_ff)) begin
            early_room_ff <= idx_q_ff;
            early_bu_ff   <= bu_q;
            early_cnt_ff  <= cnt_q;
         end
         if (cnt_q > best_cnt_ff) begin
            best_room_ff <= idx_q_ff;
            best_cnt_ff  <= cnt_q;
         end
      end
   end

   // Write-back and result
   logic [TIME_W-1:0]  begin_t;
   logic [TIME_W:0]    finish_sum;
   logic [TIME_W-1:0]  finish_t;
   logic [COUNT_W-1:0] room_cnt;
   logic               take_room;
   logic [ROOM_W-1:0]  busy_room;
   logic [COUNT_W-1:0] busy_cnt;

   assign mem_we  = (state_ff == S_UPDATE);
   assign wr_room = found_ff ? free_room_ff : early_room_ff;
   assign begin_t = found_ff ? {{(TIME_W-REQ_TIME_W){1'b0}}, start_ff} : early_bu_ff;
   assign finish_sum = {1'b0, begin_t} + {{(TIME_W+1-REQ_TIME_W){1'b0}}, dur_ff};
   assign finish_t   = finish_sum[TIME_W] ? TIME_MAX : finish_sum[TIME_W-1:0];
   assign wr_bu      = finish_t;
   assign room_cnt   = found_ff ? free_cnt_ff : early_cnt_ff;
   assign wr_cnt     = (room_cnt == COUNT_MAX) ? room_cnt : room_cnt + COUNT_W'(1);

   // The scan saw the counts before this booking, so only the chosen room can
   // overtake the busiest one found there.
   assign take_room = (wr_cnt > best_cnt_ff)
                      || ((wr_cnt == best_cnt_ff) && (wr_room < best_room_ff));
   assign busy_room = take_room ? wr_room : best_room_ff;
   assign busy_cnt  = take_room ? wr_cnt : best_cnt_ff;

   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= mem_we;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         rsp_ff.assigned_room <= ROOM_OUT_W'(wr_room);
         rsp_ff.was_delayed   <= !found_ff;
         rsp_ff.actual_begin  <= begin_t;
         rsp_ff.actual_finish <= finish_t;
         rsp_ff.busiest_room  <= ROOM_OUT_W'(busy_room);
         rsp_ff.busiest_count <= busy_cnt;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `ASSERT_NEXT(a_strobe_single, rsp_valid, !rsp_valid, "result strobe longer than one cycle")
   `ASSERT_NEXT(a_accept_busy, accept, busy && !rsp_valid, "accepted request did not go busy")
   `ASSERT_NEXT(a_update_result, state_ff == S_UPDATE, rsp_valid && !busy,
                "write-back not followed by a result")
   `ASSERT_IMPL(a_finish_order, rsp_valid,
                rsp_payload.actual_finish >= rsp_payload.actual_begin,
                "booking finishes before it begins")

endmodule
